// ===== src/vfcm_pkg.sv =====
// Shared types and constants for the voxel face culling mesher.
// Depends on nothing; imported by the mesher and its port checker.
package vfcm_pkg;

   localparam int COORD_W  = 5;
   localparam int EDGE_W   = 7;
   localparam int CFG_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int VERTEX_W = 20;
   localparam int FACES_W  = 18;
   localparam int SOLID_W  = 16;

   localparam logic [1:0] ACT_LOAD_VOXEL  = 2'd0;
   localparam logic [1:0] ACT_LOAD_BORDER = 2'd1;
   localparam logic [1:0] ACT_MESH        = 2'd2;
   localparam logic [1:0] ACT_CLEAR       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_EDGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OCCLUSION  = 2'd2;

   localparam logic [2:0] NUM_SIDES  = 3'd6;
   localparam logic [2:0] LAST_FACE  = 3'd5;
   localparam logic [7:0] SHADE_STEP = 8'd85;
   localparam logic [EDGE_W-1:0] RESET_EDGE = 7'd32;

   typedef struct packed {
      logic [1:0] occlusion;
      logic [7:0] biome;
      logic [7:0] material;
      logic       solid;
   } voxel_entry_type;

endpackage

// ===== src/voxel_face_culling_mesher.sv =====
// Top level of the voxel face culling mesher: chunk and border stores,
// neighbour read sequencer and quad emitter. Depends on vfcm_pkg.
//
// Load and clear requests leave the block idle. A mesh request that names a
// voxel inside the chunk is worked by a sequencer that reads the voxel and
// its six neighbours through the single read port of each store, one read a
// cycle, then, if the voxel is solid, walks the six faces one a cycle, an
// open face waiting while the result side stalls, and emits a quad for each
// open face; the block takes no request meanwhile. Configuration writes
// are taken at any time and must only be made while the block is idle.
// The stores need no clearing after reset.
module voxel_face_culling_mesher #(
   parameter int MAX_EDGE = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic [vfcm_pkg::COORD_W-1:0]     req_pos_x,
   input  logic [vfcm_pkg::COORD_W-1:0]     req_pos_y,
   input  logic [vfcm_pkg::COORD_W-1:0]     req_pos_z,
   input  logic [2:0]                       req_side,
   input  logic                             req_solid,
   input  logic [7:0]                       req_material,
   input  logic [7:0]                       req_biome,
   input  logic [1:0]                       req_occlusion,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2:0]                       rsp_face_dir,
   output logic [vfcm_pkg::COORD_W-1:0]     rsp_out_x,
   output logic [vfcm_pkg::COORD_W-1:0]     rsp_out_y,
   output logic [vfcm_pkg::COORD_W-1:0]     rsp_out_z,
   output logic [7:0]                       rsp_out_material,
   output logic [7:0]                       rsp_out_biome,
   output logic [7:0]                       rsp_shade,
   output logic [vfcm_pkg::VERTEX_W-1:0]    rsp_base_vertex,
   output logic [vfcm_pkg::FACES_W-1:0]     rsp_faces_emitted,
   output logic [vfcm_pkg::FACES_W-1:0]     rsp_faces_culled,
   output logic [vfcm_pkg::SOLID_W-1:0]     rsp_solid_count,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vfcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vfcm_pkg::CFG_W-1:0]       csr_data
);
   import vfcm_pkg::*;

   localparam int VOX_DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
   localparam int BRD_DEPTH = 6 * MAX_EDGE * MAX_EDGE;
   localparam int AW = $clog2(VOX_DEPTH);
   localparam int BW = $clog2(BRD_DEPTH);
   localparam logic [AW-1:0] VOX_ROW   = AW'(MAX_EDGE);
   localparam logic [AW-1:0] VOX_PLANE = AW'(MAX_EDGE * MAX_EDGE);
   localparam logic [BW-1:0] BRD_ROW   = BW'(MAX_EDGE);
   localparam logic [BW-1:0] BRD_PLANE = BW'(MAX_EDGE * MAX_EDGE);
   localparam logic [EDGE_W-1:0] MAX_EDGE_W = EDGE_W'(MAX_EDGE);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   localparam logic [1:0] SRC_AIR = 2'd0;
   localparam logic [1:0] SRC_VOX = 2'd1;
   localparam logic [1:0] SRC_BRD = 2'd2;

   localparam logic [2:0] LAST_STEP = 3'd7;

   voxel_entry_type voxel_mem [VOX_DEPTH];
   logic            border_mem [BRD_DEPTH];
   voxel_entry_type vox_rdata_ff;
   logic            brd_rdata_ff;

   logic [1:0]           state_ff, state_in;
   logic [2:0]           step_ff, step_in;
   logic [1:0]           src_ff, src_in;
   logic [2:0]           face_ff, face_in;
   logic [5:0]           air_sh_ff, air_sh_in;
   voxel_entry_type      cen_ff, cen_in;
   logic [COORD_W-1:0]   cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;

   logic [VERTEX_W-1:0]  vertex_ff, vertex_in;
   logic [FACES_W-1:0]   emitted_ff, emitted_in, culled_ff, culled_in;
   logic [SOLID_W-1:0]   solid_ff, solid_in;

   logic [CFG_W-1:0]     edge_cfg_ff, edge_cfg_in;
   logic [CFG_W-1:0]     mask_ff, mask_in;
   logic                 occ_en_ff, occ_en_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_face_ff, rsp_face_in;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [7:0]           rsp_mat_ff, rsp_mat_in, rsp_bio_ff, rsp_bio_in;
   logic [7:0]           rsp_shade_ff, rsp_shade_in;
   logic [VERTEX_W-1:0]  rsp_vertex_ff, rsp_vertex_in;
   logic [FACES_W-1:0]   rsp_emitted_ff, rsp_emitted_in, rsp_culled_ff, rsp_culled_in;
   logic [SOLID_W-1:0]   rsp_solid_ff, rsp_solid_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_fire, out_free;
   logic [EDGE_W-1:0]    edge_eff;
   logic                 vox_we, brd_we;
   logic [AW-1:0]        vox_waddr, vox_raddr;
   logic [BW-1:0]        brd_waddr, brd_raddr;
   voxel_entry_type      vox_wdata;

   logic [2:0]           fsel;
   logic [1:0]           axis;
   logic [COORD_W-1:0]   coord, coord_n, nx, ny, nz, ba, bb;
   logic                 in_chunk, present, solid_bit;
   logic [1:0]           src_sel;
   logic [7:0]           shade;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (edge_cfg_ff == '0) begin
         edge_eff = EDGE_W'(1);
      end else if (EDGE_W'(edge_cfg_ff) > MAX_EDGE_W) begin
         edge_eff = MAX_EDGE_W;
      end else begin
         edge_eff = EDGE_W'(edge_cfg_ff);
      end
   end

   // Centre and neighbour address generation for the read step.
   always_comb begin
      fsel    = (step_ff == '0) ? 3'd0 : step_ff - 3'd1;
      axis    = fsel[2:1];
      unique case (axis)
         2'd0:    coord = cx_ff;
         2'd1:    coord = cy_ff;
         default: coord = cz_ff;
      endcase
      coord_n  = fsel[0] ? coord - COORD_W'(1) : coord + COORD_W'(1);
      in_chunk = fsel[0] ? (coord != '0) : (EDGE_W'(coord) + EDGE_W'(1) < edge_eff);
      present  = (fsel < NUM_SIDES) ? mask_ff[fsel] : 1'b0;
      nx = (axis == 2'd0) ? coord_n : cx_ff;
      ny = (axis == 2'd1) ? coord_n : cy_ff;
      nz = (axis >= 2'd2) ? coord_n : cz_ff;
      unique case (axis)
         2'd0: begin
            ba = cy_ff;
            bb = cz_ff;
         end
         2'd1: begin
            ba = cx_ff;
            bb = cz_ff;
         end
         default: begin
            ba = cx_ff;
            bb = cy_ff;
         end
      endcase
      if (step_ff == '0) begin
         vox_raddr = AW'(cx_ff) + AW'(cy_ff) * VOX_ROW + AW'(cz_ff) * VOX_PLANE;
         src_sel   = SRC_VOX;
      end else begin
         vox_raddr = AW'(nx) + AW'(ny) * VOX_ROW + AW'(nz) * VOX_PLANE;
         priority if (in_chunk) begin
            src_sel = SRC_VOX;
         end else if (present) begin
            src_sel = SRC_BRD;
         end else begin
            src_sel = SRC_AIR;
         end
      end
      brd_raddr = BW'(fsel) * BRD_PLANE + BW'(ba) + BW'(bb) * BRD_ROW;
   end

   always_comb begin
      vox_we    = req_fire && (req_action == ACT_LOAD_VOXEL)
                  && (EDGE_W'(req_pos_x) < MAX_EDGE_W) && (EDGE_W'(req_pos_y) < MAX_EDGE_W)
                  && (EDGE_W'(req_pos_z) < MAX_EDGE_W);
      brd_we    = req_fire && (req_action == ACT_LOAD_BORDER) && (req_side < NUM_SIDES)
                  && (EDGE_W'(req_pos_x) < MAX_EDGE_W) && (EDGE_W'(req_pos_y) < MAX_EDGE_W);
      vox_waddr = AW'(req_pos_x) + AW'(req_pos_y) * VOX_ROW + AW'(req_pos_z) * VOX_PLANE;
      brd_waddr = BW'(req_side) * BRD_PLANE + BW'(req_pos_x) + BW'(req_pos_y) * BRD_ROW;
      vox_wdata = '{occlusion: req_occlusion, biome: req_biome,
                    material: req_material, solid: req_solid};
   end

   always_ff @(posedge clock) begin
      if (vox_we) begin
         voxel_mem[vox_waddr] <= vox_wdata;
      end
      vox_rdata_ff <= voxel_mem[vox_raddr];
   end

   always_ff @(posedge clock) begin
      if (brd_we) begin
         border_mem[brd_waddr] <= req_solid;
      end
      brd_rdata_ff <= border_mem[brd_raddr];
   end

   always_comb begin
      unique case (src_ff)
         SRC_VOX: solid_bit = vox_rdata_ff.solid;
         SRC_BRD: solid_bit = brd_rdata_ff;
         default: solid_bit = 1'b0;
      endcase
      shade = occ_en_ff ? 8'(cen_ff.occlusion) * SHADE_STEP : 8'd0;
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      src_in    = src_sel;
      face_in   = face_ff;
      air_sh_in = air_sh_ff;
      cen_in    = cen_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      vertex_in  = vertex_ff;
      emitted_in = emitted_ff;
      culled_in  = culled_ff;
      solid_in   = solid_ff;

      edge_cfg_in = edge_cfg_ff;
      mask_in     = mask_ff;
      occ_en_in   = occ_en_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CHUNK_EDGE: edge_cfg_in = csr_data;
            CSR_PRESENT:    mask_in     = csr_data;
            CSR_OCCLUSION:  occ_en_in   = csr_data[0];
            default:        ;
         endcase
      end

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_face_in    = rsp_face_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_z_in       = rsp_z_ff;
      rsp_mat_in     = rsp_mat_ff;
      rsp_bio_in     = rsp_bio_ff;
      rsp_shade_in   = rsp_shade_ff;
      rsp_vertex_in  = rsp_vertex_ff;
      rsp_emitted_in = rsp_emitted_ff;
      rsp_culled_in  = rsp_culled_ff;
      rsp_solid_in   = rsp_solid_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cx_in = req_pos_x;
               cy_in = req_pos_y;
               cz_in = req_pos_z;
               unique case (req_action)
                  ACT_CLEAR: begin
                     vertex_in  = '0;
                     emitted_in = '0;
                     culled_in  = '0;
                     solid_in   = '0;
                  end
                  ACT_MESH: begin
                     if ((EDGE_W'(req_pos_x) < edge_eff) && (EDGE_W'(req_pos_y) < edge_eff)
                         && (EDGE_W'(req_pos_z) < edge_eff)) begin
                        state_in = S_READ;
                        step_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd1) begin
               cen_in = vox_rdata_ff;
            end else if (step_ff != '0) begin
               air_sh_in = {!solid_bit, air_sh_ff[5:1]};
            end
            if (step_ff == LAST_STEP) begin
               face_in = '0;
               if (cen_ff.solid) begin
                  state_in = S_EMIT;
                  solid_in = solid_ff + SOLID_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (!air_sh_ff[0] || out_free) begin
               if (air_sh_ff[0]) begin
                  rsp_valid_in   = 1'b1;
                  rsp_face_in    = face_ff;
                  rsp_x_in       = cx_ff;
                  rsp_y_in       = cy_ff;
                  rsp_z_in       = cz_ff;
                  rsp_mat_in     = cen_ff.material;
                  rsp_bio_in     = cen_ff.biome;
                  rsp_shade_in   = shade;
                  rsp_vertex_in  = vertex_ff;
                  rsp_emitted_in = emitted_ff + FACES_W'(1);
                  rsp_culled_in  = culled_ff;
                  rsp_solid_in   = solid_ff;
                  rsp_last_in    = (air_sh_ff[5:1] == '0);
                  emitted_in     = emitted_ff + FACES_W'(1);
                  vertex_in      = vertex_ff + VERTEX_W'(4);
               end else begin
                  culled_in = culled_ff + FACES_W'(1);
               end
               air_sh_in = {1'b0, air_sh_ff[5:1]};
               face_in   = face_ff + 3'd1;
               if (face_ff == LAST_FACE) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         face_ff      <= '0;
         vertex_ff    <= '0;
         emitted_ff   <= '0;
         culled_ff    <= '0;
         solid_ff     <= '0;
         edge_cfg_ff  <= CFG_W'(RESET_EDGE);
         mask_ff      <= '0;
         occ_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         face_ff      <= face_in;
         vertex_ff    <= vertex_in;
         emitted_ff   <= emitted_in;
         culled_ff    <= culled_in;
         solid_ff     <= solid_in;
         edge_cfg_ff  <= edge_cfg_in;
         mask_ff      <= mask_in;
         occ_en_ff    <= occ_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      air_sh_ff      <= air_sh_in;
      cen_ff         <= cen_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      cz_ff          <= cz_in;
      rsp_face_ff    <= rsp_face_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_z_ff       <= rsp_z_in;
      rsp_mat_ff     <= rsp_mat_in;
      rsp_bio_ff     <= rsp_bio_in;
      rsp_shade_ff   <= rsp_shade_in;
      rsp_vertex_ff  <= rsp_vertex_in;
      rsp_emitted_ff <= rsp_emitted_in;
      rsp_culled_ff  <= rsp_culled_in;
      rsp_solid_ff   <= rsp_solid_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_face_dir      = rsp_face_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_z         = rsp_z_ff;
   assign rsp_out_material  = rsp_mat_ff;
   assign rsp_out_biome     = rsp_bio_ff;
   assign rsp_shade         = rsp_shade_ff;
   assign rsp_base_vertex   = rsp_vertex_ff;
   assign rsp_faces_emitted = rsp_emitted_ff;
   assign rsp_faces_culled  = rsp_culled_ff;
   assign rsp_solid_count   = rsp_solid_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== src/vfcm_checker.sv =====
// Port-level checks for the voxel face culling mesher, with the bind that
// attaches them to the top level. Depends on vfcm_pkg.
module vfcm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [1:0]                     req_action,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [2:0]                     rsp_face_dir,
   input logic [vfcm_pkg::VERTEX_W-1:0]  rsp_base_vertex,
   input logic [vfcm_pkg::FACES_W-1:0]   rsp_faces_emitted,
   input logic                           rsp_last
);
   import vfcm_pkg::*;

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_face_dir)
         && $stable(rsp_base_vertex) && $stable(rsp_faces_emitted) && $stable(rsp_last))
      else $error("stalled result changed");

   // Quads take four vertices each, so the base vertex stays aligned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_base_vertex[1:0] == 2'b00)
      else $error("base vertex not aligned to a quad");

   // Loads and clears finish in the cycle they are taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action != ACT_MESH |=> !req_stall)
      else $error("block busy after a load or clear request");

   // While a mesh request still has quads to come, no new request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken before the last quad");

   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind voxel_face_culling_mesher vfcm_checker u_vfcm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_face_dir      (rsp_face_dir),
   .rsp_base_vertex   (rsp_base_vertex),
   .rsp_faces_emitted (rsp_faces_emitted),
   .rsp_last          (rsp_last)
);
